[rtl/assert_macros.svh]
// Assertion macros shared by the RTL; they compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define SCET_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define SCET_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SCET_ASSERT_NOW(lbl, ante, cons)
`define SCET_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/scet_pkg.sv]
// Shared types and constants of the sphere contact event tracker.
`default_nettype none
package scet_pkg;

	localparam int COLLIDER_ID_W = 8;
	localparam int COORD_W       = 24;
	localparam int RADIUS_W      = 23;

	// Queue between the classifying front and the bitmap back end.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_ENTER = 2'd1,
		EV_STAY  = 2'd2,
		EV_EXIT  = 2'd3
	} event_kind_t;

	// One ordered pair of sphere colliders.
	typedef struct packed {
		logic [COLLIDER_ID_W-1:0] left_id;
		logic [COLLIDER_ID_W-1:0] partner_id;
		logic                     left_valid;
		logic                     right_valid;
		logic [COORD_W-1:0]       left_x;
		logic [COORD_W-1:0]       left_y;
		logic [COORD_W-1:0]       left_z;
		logic [RADIUS_W-1:0]      left_radius;
		logic [COORD_W-1:0]       right_x;
		logic [COORD_W-1:0]       right_y;
		logic [COORD_W-1:0]       right_z;
		logic [RADIUS_W-1:0]      right_radius;
	} pair_t;

	// One contact event.
	typedef struct packed {
		event_kind_t        event_kind;
		logic [COORD_W-1:0] contact_x;
		logic [COORD_W-1:0] contact_y;
		logic [COORD_W-1:0] contact_z;
	} event_t;

	// Classified pair handed from the front to the back end.
	typedef struct packed {
		logic [COLLIDER_ID_W-1:0] left_id;
		logic [COLLIDER_ID_W-1:0] partner_id;
		logic                     skip;
		logic                     hit;
		logic [COORD_W-1:0]       mid_x;
		logic [COORD_W-1:0]       mid_y;
		logic [COORD_W-1:0]       mid_z;
	} work_t;

endpackage
`default_nettype wire

[rtl/scet_pair_if.sv]
// Valid/ready channel that carries collider pairs.
`default_nettype none
interface scet_pair_if;
	import scet_pkg::*;

	logic  valid;
	logic  ready;
	pair_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/scet_event_if.sv]
// Valid/ready channel that carries contact events.
`default_nettype none
interface scet_event_if;
	import scet_pkg::*;

	logic   valid;
	logic   ready;
	event_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/scet_front.sv]
// Front part: accepts pairs and classifies them through a three-stage distance test.
`default_nettype none
module scet_front #(
	parameter int MAX_COLLIDERS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	scet_pair_if.sink                       pairs,
	input  logic                            clear_busy,
	input  logic [scet_pkg::FIFO_CNT_W-1:0] fifo_count,
	output logic                            push,
	output scet_pkg::work_t                 push_item
);
	import scet_pkg::*;

	localparam int SUM_W = FIFO_CNT_W + 1;

	logic                      accept;
	logic [SUM_W-1:0]          slots_used;
	logic signed [COORD_W:0]   dx_in, dy_in, dz_in;
	logic [COORD_W:0]          sx_in, sy_in, sz_in;
	logic [COORD_W-1:0]        rsum_in;
	logic                      id_bad;
	logic                      valid_s1, valid_s2, valid_s3;
	logic signed [COORD_W:0]   dx_s1, dy_s1, dz_s1;
	logic [COORD_W-1:0]        rsum_s1;
	logic                      both_s1, both_s2;
	work_t                     item_s1, item_s2, item_s3;
	work_t                     item_hit_s2;
	logic signed [2*COORD_W+1:0] prod_x, prod_y, prod_z;
	logic [2*COORD_W-1:0]      rsq_prod;
	logic [2*COORD_W:0]        dx2_s2, dy2_s2, dz2_s2;
	logic [2*COORD_W-1:0]      rsq_s2;
	logic [2*COORD_W+2:0]      dist_sq;
	logic                      hit_s2;

	// Every accepted pair holds a queue slot, so the stages never stall.
	assign slots_used = SUM_W'(fifo_count) + SUM_W'(valid_s1) + SUM_W'(valid_s2)
		+ SUM_W'(valid_s3);
	assign pairs.ready = !clear_busy && (slots_used < SUM_W'(FIFO_DEPTH));
	assign accept = pairs.valid && pairs.ready;

	// Centre differences, centre sums and the radius sum, all exact.
	assign dx_in = {pairs.data.right_x[COORD_W-1], pairs.data.right_x}
		- {pairs.data.left_x[COORD_W-1], pairs.data.left_x};
	assign dy_in = {pairs.data.right_y[COORD_W-1], pairs.data.right_y}
		- {pairs.data.left_y[COORD_W-1], pairs.data.left_y};
	assign dz_in = {pairs.data.right_z[COORD_W-1], pairs.data.right_z}
		- {pairs.data.left_z[COORD_W-1], pairs.data.left_z};
	assign sx_in = {pairs.data.right_x[COORD_W-1], pairs.data.right_x}
		+ {pairs.data.left_x[COORD_W-1], pairs.data.left_x};
	assign sy_in = {pairs.data.right_y[COORD_W-1], pairs.data.right_y}
		+ {pairs.data.left_y[COORD_W-1], pairs.data.left_y};
	assign sz_in = {pairs.data.right_z[COORD_W-1], pairs.data.right_z}
		+ {pairs.data.left_z[COORD_W-1], pairs.data.left_z};
	assign rsum_in = {1'b0, pairs.data.left_radius} + {1'b0, pairs.data.right_radius};

	// Pairs of one collider with itself, or with an id out of range, leave the bitmap alone.
	assign id_bad = (32'(pairs.data.left_id) >= 32'(MAX_COLLIDERS))
		|| (32'(pairs.data.partner_id) >= 32'(MAX_COLLIDERS));

	// Squares of the differences and of the radius sum.
	assign prod_x   = dx_s1 * dx_s1;
	assign prod_y   = dy_s1 * dy_s1;
	assign prod_z   = dz_s1 * dz_s1;
	assign rsq_prod = rsum_s1 * rsum_s1;

	// Contact test: both colliders valid and squared distance at most the squared radius sum.
	assign dist_sq = {2'b00, dx2_s2} + {2'b00, dy2_s2} + {2'b00, dz2_s2};
	assign hit_s2  = both_s2 && (dist_sq <= {3'b000, rsq_s2});

	// Second-stage item with its contact result filled in.
	always_comb begin
		item_hit_s2     = item_s2;
		item_hit_s2.hit = hit_s2;
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		dx_s1              <= dx_in;
		dy_s1              <= dy_in;
		dz_s1              <= dz_in;
		rsum_s1            <= rsum_in;
		both_s1            <= pairs.data.left_valid && pairs.data.right_valid;
		item_s1.left_id    <= pairs.data.left_id;
		item_s1.partner_id <= pairs.data.partner_id;
		item_s1.skip       <= (pairs.data.left_id == pairs.data.partner_id) || id_bad;
		item_s1.hit        <= 1'b0;
		item_s1.mid_x      <= sx_in[COORD_W:1];
		item_s1.mid_y      <= sy_in[COORD_W:1];
		item_s1.mid_z      <= sz_in[COORD_W:1];

		dx2_s2  <= prod_x[2*COORD_W:0];
		dy2_s2  <= prod_y[2*COORD_W:0];
		dz2_s2  <= prod_z[2*COORD_W:0];
		rsq_s2  <= rsq_prod;
		both_s2 <= both_s1;
		item_s2 <= item_s1;

		item_s3 <= item_hit_s2;
	end

	assign push      = valid_s3;
	assign push_item = item_s3;
endmodule
`default_nettype wire

[rtl/scet_fifo.sv]
// Short queue of classified pairs between the front and the back end.
`default_nettype none
module scet_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  scet_pkg::work_t                 push_item,
	input  logic                            pop,
	output scet_pkg::work_t                 head,
	output logic                            empty,
	output logic [scet_pkg::FIFO_CNT_W-1:0] count
);
	import scet_pkg::*;

	work_t                 slots [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_item;
		end
	end

	assign head  = slots[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;
endmodule
`default_nettype wire

[rtl/scet_back.sv]
// Back end: contact bitmap read-modify-write, event decision and output register.
`default_nettype none
module scet_back #(
	parameter int MAX_COLLIDERS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  scet_pkg::work_t head,
	input  logic            empty,
	output logic            pop,
	output logic            clear_busy,
	scet_event_if.source    events
);
	import scet_pkg::*;

	localparam int ID_W  = (MAX_COLLIDERS >= (1 << COLLIDER_ID_W)) ? COLLIDER_ID_W
		: $clog2(MAX_COLLIDERS);
	localparam int IDX_W = 2 * ID_W;
	localparam int DEPTH = 1 << IDX_W;

	logic             contact_mem [DEPTH];
	logic [IDX_W-1:0] clr_idx_q;
	logic             clr_busy_q;
	logic [IDX_W-1:0] head_idx, idx_s1;
	work_t            item_s1;
	logic             vld_s1;
	logic             prev_s1;
	logic             out_free, fire, wr_en;
	event_t           result, out_q;
	logic             out_valid_q;

	assign head_idx = {head.left_id[ID_W-1:0], head.partner_id[ID_W-1:0]};
	assign idx_s1   = {item_s1.left_id[ID_W-1:0], item_s1.partner_id[ID_W-1:0]};

	// Handshake between the queue head, the bitmap stage and the output register.
	assign out_free = !out_valid_q || events.ready;
	assign fire     = vld_s1 && out_free;
	assign pop      = !empty && !clr_busy_q && (!vld_s1 || fire);
	assign wr_en    = fire && !item_s1.skip;

	// The new contact bit is the contact test itself; the event follows from old and new.
	always_comb begin
		result.event_kind = EV_NONE;
		result.contact_x  = '0;
		result.contact_y  = '0;
		result.contact_z  = '0;
		if (!item_s1.skip) begin
			if (prev_s1) begin
				result.event_kind = item_s1.hit ? EV_STAY : EV_EXIT;
			end else if (item_s1.hit) begin
				result.event_kind = EV_ENTER;
				result.contact_x  = item_s1.mid_x;
				result.contact_y  = item_s1.mid_y;
				result.contact_z  = item_s1.mid_z;
			end
		end
	end

	// Clearing pass over the bitmap after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Bitmap write port and registered read, forwarding a same-edge write.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			contact_mem[clr_idx_q] <= 1'b0;
		end else if (wr_en) begin
			contact_mem[idx_s1] <= item_s1.hit;
		end
		if (pop) begin
			item_s1 <= head;
			if (wr_en && (idx_s1 == head_idx)) begin
				prev_s1 <= item_s1.hit;
			end else begin
				prev_s1 <= contact_mem[head_idx];
			end
		end
		if (fire) begin
			out_q <= result;
		end
	end

	// Stage and output valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= vld_s1;
			end
		end
	end

	assign clear_busy   = clr_busy_q;
	assign events.valid = out_valid_q;
	assign events.data  = out_q;
endmodule
`default_nettype wire

[rtl/sphere_contact_event_tracker_unit.sv]
// Top level of the sphere contact event tracker.
`default_nettype none
`include "assert_macros.svh"
// Each pair beat yields exactly one event beat (NONE, ENTER with the midpoint of the centres,
// STAY or EXIT), in order. The block sustains one pair per clock while the event output is
// not stalled: the front runs a three-stage distance test, and the back end does one
// read-modify-write of the contact bitmap per pair, with a same-address write forwarded into
// the next read. Each pair passes the front's stages, the queue, the bitmap stage and the
// output register before its event is offered. After reset the bitmap is cleared one bit per
// cycle over all 2^(2*W) bits, where W is 8 for MAX_COLLIDERS of 256 or more and
// clog2(MAX_COLLIDERS) below (65536 bits at the default), and no pair is taken until the
// pass ends.
module sphere_contact_event_tracker_unit #(
	parameter int MAX_COLLIDERS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	scet_pair_if.sink    pairs,
	scet_event_if.source events
);
	import scet_pkg::*;

	logic                  clear_busy;
	logic                  push, pop, empty;
	work_t                 push_item, head;
	logic [FIFO_CNT_W-1:0] fifo_count;

	scet_front #(
		.MAX_COLLIDERS(MAX_COLLIDERS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pairs     (pairs),
		.clear_busy(clear_busy),
		.fifo_count(fifo_count),
		.push      (push),
		.push_item (push_item)
	);

	scet_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.count    (fifo_count)
	);

	scet_back #(
		.MAX_COLLIDERS(MAX_COLLIDERS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.clear_busy(clear_busy),
		.events    (events)
	);

	// The slot reserved at acceptance must still be free when the pair reaches the queue.
	`SCET_ASSERT_NOW(a_queue_room, push, fifo_count < FIFO_CNT_W'(FIFO_DEPTH))
	// No pair enters while the bitmap is being cleared.
	`SCET_ASSERT_NOW(a_no_accept_clear, pairs.valid && pairs.ready, !clear_busy)
	// The clearing pass runs once, right after reset.
	`SCET_ASSERT_NEXT(a_clear_once, !clear_busy, !clear_busy)
	// Nothing reaches the queue or the back end during the clearing pass.
	`SCET_ASSERT_NOW(a_idle_clear, clear_busy, !push && !pop && empty)
endmodule
`default_nettype wire

[bench/sphere_contact_event_tracker_unit_test.sv]
// Self-checking testbench of the sphere contact event tracker: random and directed pair beats.
`timescale 1ns / 100ps
module sphere_contact_event_tracker_unit_test;
	import scet_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Bench-side copies of the block inputs, known from time zero.
	logic  pair_valid = 1'b0;
	pair_t pair_data = '0;
	logic  event_ready = 1'b0;

	scet_pair_if  pairs_if ();
	scet_event_if events_if ();

	assign pairs_if.valid = pair_valid;
	assign pairs_if.data = pair_data;
	assign events_if.ready = event_ready;

	sphere_contact_event_tracker_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pairs(pairs_if),
		.events(events_if)
	);

	// Pairs waiting to be offered, and events predicted for accepted pairs.
	pair_t  pending_pairs[$];
	event_t expected_events[$];

	// Contact bit per ordered pair, indexed by {left_id, partner_id}.
	bit contact_map [0:65535];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_trigger = 1'b0;
	int hold_left = 0;
	int error_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sign-extends a centre coordinate by one bit.
	function automatic logic signed [COORD_W:0] widen(input logic [COORD_W-1:0] c);
		return $signed({c[COORD_W-1], c});
	endfunction

	// Midpoint of two coordinates, rounded toward minus infinity.
	function automatic logic [COORD_W-1:0] midpoint(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic signed [COORD_W:0] s;
		s = widen(a) + widen(b);
		s = s >>> 1;
		return s[COORD_W-1:0];
	endfunction

	// Predicts the event of one pair beat and updates the contact map.
	function automatic event_t track_pair(input pair_t p);
		event_t ev;
		longint dx, dy, dz, d2, rs;
		int unsigned idx;
		logic was_touching;
		logic touching;
		ev = '0;
		ev.event_kind = EV_NONE;
		if (p.left_id == p.partner_id)
			return ev;
		idx = {p.left_id, p.partner_id};
		was_touching = contact_map[idx];
		touching = 1'b0;
		if (p.left_valid && p.right_valid) begin
			dx = widen(p.right_x) - widen(p.left_x);
			dy = widen(p.right_y) - widen(p.left_y);
			dz = widen(p.right_z) - widen(p.left_z);
			d2 = dx * dx + dy * dy + dz * dz;
			rs = longint'(p.left_radius) + longint'(p.right_radius);
			touching = (d2 <= rs * rs);
		end
		if (was_touching) begin
			if (touching) begin
				ev.event_kind = EV_STAY;
			end else begin
				ev.event_kind = EV_EXIT;
				contact_map[idx] = 1'b0;
			end
		end else if (touching) begin
			ev.event_kind = EV_ENTER;
			ev.contact_x = midpoint(p.left_x, p.right_x);
			ev.contact_y = midpoint(p.left_y, p.right_y);
			ev.contact_z = midpoint(p.left_z, p.right_z);
			contact_map[idx] = 1'b1;
		end
		return ev;
	endfunction

	// Builds one pair from plain integers.
	function automatic pair_t pair_of(input int lid, input int rid, input bit lv, input bit rv,
			input int lx, input int ly, input int lz, input int lr,
			input int rx, input int ry, input int rz, input int rr);
		pair_t p;
		p.left_id = lid[COLLIDER_ID_W-1:0];
		p.partner_id = rid[COLLIDER_ID_W-1:0];
		p.left_valid = lv;
		p.right_valid = rv;
		p.left_x = lx[COORD_W-1:0];
		p.left_y = ly[COORD_W-1:0];
		p.left_z = lz[COORD_W-1:0];
		p.left_radius = lr[RADIUS_W-1:0];
		p.right_x = rx[COORD_W-1:0];
		p.right_y = ry[COORD_W-1:0];
		p.right_z = rz[COORD_W-1:0];
		p.right_radius = rr[RADIUS_W-1:0];
		return p;
	endfunction

	// Mostly near pairs among a few colliders, so contacts enter, stay and exit;
	// the rest is full-range noise.
	function automatic pair_t random_pair();
		int bx, by, bz;
		if ($urandom_range(99) < 80) begin
			bx = $urandom_range(8388607) - 4194304;
			by = $urandom_range(8388607) - 4194304;
			bz = $urandom_range(8388607) - 4194304;
			return pair_of($urandom_range(5), $urandom_range(5),
				$urandom_range(99) < 92, $urandom_range(99) < 92,
				bx, by, bz, $urandom_range(1023),
				bx + $urandom_range(3000) - 1500, by + $urandom_range(3000) - 1500,
				bz + $urandom_range(3000) - 1500, $urandom_range(1023));
		end
		return pair_of($urandom(), $urandom(), $urandom_range(1), $urandom_range(1),
			$urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom());
	endfunction

	// Appends one pair to the pending queue.
	task automatic queue_pair(input pair_t p);
		pending_pairs = {pending_pairs, p};
	endtask

	// Pair driver: predicts each accepted beat and offers the next pending pair.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid <= 1'b0;
			pair_data <= '0;
		end else begin
			if (pair_valid && pairs_if.ready)
				expected_events = {expected_events, track_pair(pair_data)};
			if (!pair_valid || pairs_if.ready) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pair_valid <= 1'b1;
					pair_data <= pending_pairs.pop_front();
				end else begin
					pair_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted down once triggered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_trigger) begin
			hold_left <= 200;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Event monitor: compares each accepted beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		event_t want;
		if (!arst_n) begin
			event_ready <= 1'b0;
		end else begin
			if (events_if.valid && event_ready) begin
				if (expected_events.size() == 0) begin
					if (error_count < 10)
						$display("%0t: event beat with nothing expected: kind %0d",
							$realtime, events_if.data.event_kind);
					error_count <= error_count + 1;
				end else begin
					want = expected_events.pop_front();
					if (events_if.data.event_kind !== want.event_kind
							|| events_if.data.contact_x !== want.contact_x
							|| events_if.data.contact_y !== want.contact_y
							|| events_if.data.contact_z !== want.contact_z) begin
						if (error_count < 10)
							$display("%0t: expected kind %0d at (%h %h %h), got kind %0d at (%h %h %h)",
								$realtime, want.event_kind, want.contact_x, want.contact_y,
								want.contact_z, events_if.data.event_kind,
								events_if.data.contact_x, events_if.data.contact_y,
								events_if.data.contact_z);
						error_count <= error_count + 1;
					end
				end
			end
			event_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Blocks until every pending pair is accepted and every event has come back.
	task automatic wait_drained();
		while (pending_pairs.size() != 0 || pair_valid || expected_events.size() != 0)
			@(negedge clk);
	endtask

	// Sequence of phases.
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 18;
		recv_idle_pct = 66;
		// Enter, stay, exit on an invalid collider, then nothing while apart.
		queue_pair(pair_of(1, 2, 1, 1, 0, 0, 0, 1, 0, 0, 0, 1));
		queue_pair(pair_of(1, 2, 1, 1, 0, 0, 0, 1, 0, 0, 0, 1));
		queue_pair(pair_of(1, 2, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
		queue_pair(pair_of(1, 2, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
		// Touching exactly at the sum of radii, then one step apart.
		queue_pair(pair_of(1, 2, 1, 1, 0, 0, 0, 256, 512, 0, 0, 256));
		queue_pair(pair_of(1, 2, 1, 1, 0, 0, 0, 256, 513, 0, 0, 256));
		queue_pair(pair_of(1, 2, 1, 1, 0, 0, 0, 256, 513, 0, 0, 256));
		// The reversed order is a pair of its own.
		queue_pair(pair_of(2, 1, 1, 1, 0, 0, 0, 256, 512, 0, 0, 256));
		// Equal ids never give an event.
		queue_pair(pair_of(3, 3, 1, 1, 0, 0, 0, 100, 0, 0, 0, 100));
		queue_pair(pair_of(255, 255, 1, 1, 5, 5, 5, 9, 5, 5, 5, 9));
		// Coordinate and radius extremes, far apart.
		queue_pair(pair_of(255, 0, 1, 1, 8388607, 8388607, 8388607, 8388607,
			-8388608, -8388608, -8388608, 8388607));
		// Maximal and minimal midpoints.
		queue_pair(pair_of(255, 0, 1, 1, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, 8388607));
		queue_pair(pair_of(0, 255, 1, 1, -8388608, -8388608, -8388608, 0,
			-8388608, -8388608, -8388608, 0));
		// Midpoint of an odd negative sum rounds down.
		queue_pair(pair_of(4, 5, 1, 1, -1, -3, 1, 10, 0, 0, 0, 10));
		// Zero radii at distinct centres exit; the second collider invalid exits too.
		queue_pair(pair_of(0, 255, 1, 1, -8388608, -8388608, -8388608, 0,
			-8388607, -8388608, -8388608, 0));
		queue_pair(pair_of(255, 0, 1, 0, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, 8388607));
		queue_pair(pair_of(255, 0, 1, 0, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, 8388607));
		// Both invalid while in contact.
		queue_pair(pair_of(4, 5, 0, 0, -1, -3, 1, 10, 0, 0, 0, 10));
		queue_pair(pair_of(2, 1, 0, 0, 0, 0, 0, 256, 512, 0, 0, 256));
		wait_drained();

		repeat (330) queue_pair(random_pair());
		wait_drained();

		@(negedge clk);
		send_idle_pct = 66;
		recv_idle_pct = 18;
		repeat (330) queue_pair(random_pair());
		wait_drained();

		// No idling, with a long stall of the event side while pairs keep coming.
		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (340) queue_pair(random_pair());
		repeat (3) @(negedge clk);
		hold_trigger = 1'b1;
		@(negedge clk);
		hold_trigger = 1'b0;
		wait_drained();

		repeat (20) @(negedge clk);
		if (error_count == 0 && expected_events.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
